### rtl/core/serial_flash_loader_protocol_macros.svh
// Assertion macros used by the loader back end (sfl_back)
`ifndef SERIAL_FLASH_LOADER_PROTOCOL_MACROS_SVH
`define SERIAL_FLASH_LOADER_PROTOCOL_MACROS_SVH
// Antecedent implies consequent on the same edge
`define SFL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent on the next edge
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Types and constants of the serial flash loader.
// ----------------------------------------------------------------------------
package sfl_pkg;

    typedef enum logic [1:0] {
        OP_RX_BYTE   = 2'd0,
        OP_TIMEOUT   = 2'd1,
        OP_FLASH_DONE = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2,
        CMD_RSVD    = 2'd3
    } flash_cmd_t;

    typedef enum logic [2:0] {
        PH_HANDSHAKE   = 3'd0,
        PH_COMMAND     = 3'd1,
        PH_ERASING     = 3'd2,
        PH_RECEIVING   = 3'd3,
        PH_PROGRAMMING = 3'd4,
        PH_ENDED       = 3'd5
    } phase_t;

    localparam logic [1:0] REG_DEVICE_CODE   = 2'd0;
    localparam logic [1:0] REG_PROGRAM_PAGES = 2'd1;
    localparam logic [1:0] REG_BOOT_PAGES    = 2'd2;

    localparam logic [7:0] BYTE_HELLO = 8'hC1;
    localparam logic [7:0] BYTE_E     = 8'h45;
    localparam logic [7:0] BYTE_C     = 8'h43;
    localparam logic [7:0] BYTE_K     = 8'h4B;

    localparam logic [28:0] BOOT_BASE = 29'h1FC00000;
    localparam logic [28:0] PROG_BASE = 29'h1D000000;

    // One result beat
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  flash_command;
        logic [28:0] flash_address;
        logic [31:0] flash_word;
        logic        start_application;
        logic        dropped;
        logic        last;
    } result_t;

    // Classified event from the front end
    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } event_t;

endpackage

### rtl/core/sfl_if.sv
// ----------------------------------------------------------------------------
// sfl_in_if / sfl_out_if / sfl_cfg_if
// Valid/ready channels of the serial flash loader.
// ----------------------------------------------------------------------------
interface sfl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfl_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  flash_command;
    logic [28:0] flash_address;
    logic [31:0] flash_word;
    logic        start_application;
    logic        dropped;
    logic        last;
    modport source (output valid, output tx_valid, output tx_byte, output flash_command,
                    output flash_address, output flash_word, output start_application,
                    output dropped, output last, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input flash_command,
                    input flash_address, input flash_word, input start_application,
                    input dropped, input last, output ready);
endinterface

interface sfl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sfl_front.sv
// ----------------------------------------------------------------------------
// sfl_front
// Accepts input beats and queues them as events for the back end.
// Two-entry queue; operation 3 is discarded here.
// ----------------------------------------------------------------------------
module sfl_front
    import sfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_operation,
    input  logic [7:0] in_rx_byte,
    output logic       ev_valid,
    input  logic       ev_take,
    output event_t     ev
);

    event_t     q_reg [2];
    logic [1:0] count_reg;
    logic       rd_reg;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_operation != OP_UNUSED);
    assign ev_valid = (count_reg != 2'd0);
    assign pop      = ev_valid && ev_take;
    assign ev       = q_reg[rd_reg];

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

    // Queue storage: tail sits one past the head when an entry is held
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[rd_reg ^ (count_reg != 2'd0)] <= '{op: op_t'(in_operation),
                                                   rx_byte: in_rx_byte};
    end

endmodule

### rtl/core/sfl_back.sv
// ----------------------------------------------------------------------------
// sfl_back
// Protocol engine: consumes one event per cycle while its two-deep output
// buffer is empty and no word read pends, emitting up to two result beats.
// ----------------------------------------------------------------------------
module sfl_back
    import sfl_pkg::*;
#(
    parameter int PAGE_BYTES       = 4096,
    parameter int MAX_PACKET_WORDS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       ev_valid,
    output logic       ev_take,
    input  event_t     ev,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);
`include "serial_flash_loader_protocol_macros.svh"

    localparam int WW = (MAX_PACKET_WORDS > 1) ? $clog2(MAX_PACKET_WORDS) : 1;

    logic [7:0]  dev_reg, ppages_reg;
    logic [1:0]  bpages_reg;
    phase_t      phase_reg, phase_next;
    logic [8:0]  bidx_reg, bidx_next;
    logic [7:0]  dcount_reg, dcount_next;
    logic        zone_reg, zone_next;
    logic [23:0] paddr_reg, paddr_next;
    logic [6:0]  cur_reg, cur_next;
    logic [7:0]  page_reg, page_next;
    logic        pz_reg, pz_next;
    logic [31:0] wbuf [MAX_PACKET_WORDS];
    logic        wr_en;
    logic [WW-1:0] wr_idx;
    logic [31:0] wr_data;
    logic [WW-1:0] rd_idx;
    logic [31:0] rd_data;

    // Output buffer: two result slots
    result_t     ob_reg [2];
    logic [1:0]  ocnt_reg;
    logic        ord_reg;
    result_t     r0, r1;
    logic [1:0]  nres;
    logic        proc;
    logic        pend_reg;
    result_t     pend_res_reg;
    logic        pend_prog_reg;
    logic [6:0]  pend_cur_reg;

    // Word total of the current packet
    function automatic logic [6:0] wtotal(input logic [7:0] dc);
        logic [6:0] n;
        n = 7'((9'(dc) + 9'd3) >> 2);
        return (n > 7'(MAX_PACKET_WORDS)) ? 7'(MAX_PACKET_WORDS) : n;
    endfunction

    function automatic result_t tx(input logic [7:0] b);
        result_t r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        return r;
    endfunction

    // Erase result for page p of the zone z
    function automatic result_t erase_res(input logic z, input logic [7:0] p);
        result_t r;
        r = '0;
        r.flash_command = CMD_ERASE;
        r.flash_address = (z ? PROG_BASE : BOOT_BASE) + 29'(p) * 29'(PAGE_BYTES);
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg    <= 8'hD6;
            ppages_reg <= 8'd127;
            bpages_reg <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_CODE:   dev_reg    <= cfg_data;
                REG_PROGRAM_PAGES: ppages_reg <= cfg_data;
                REG_BOOT_PAGES:    bpages_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Program results get their buffer word in the next cycle; the pending slot
    // holds that beat until its word arrives.
    assign proc    = ev_valid && (ocnt_reg == 2'd0) && !pend_reg;
    assign ev_take = proc;

    // Protocol next state and results
    always_comb
    begin
        logic       settle_ok;
        logic       pz;
        logic [7:0] pg;
        logic [8:0] d;
        phase_next  = phase_reg;
        bidx_next   = bidx_reg;
        dcount_next = dcount_reg;
        zone_next   = zone_reg;
        paddr_next  = paddr_reg;
        cur_next    = cur_reg;
        page_next   = page_reg;
        pz_next     = pz_reg;
        r0 = '0;
        r1 = '0;
        nres = 2'd0;
        wr_en = 1'b0;
        wr_idx = '0;
        wr_data = '0;
        settle_ok = 1'b0;
        pz = 1'b0;
        pg = '0;
        d = '0;
        rd_idx = '0;
        if (proc)
        begin
            case (phase_reg)
                PH_HANDSHAKE, PH_COMMAND:
                begin
                    if (ev.op == OP_RX_BYTE && phase_reg == PH_HANDSHAKE
                        && ev.rx_byte == BYTE_HELLO)
                    begin
                        r0 = tx(dev_reg);
                        r1 = tx(BYTE_K);
                        nres = 2'd2;
                        phase_next = PH_COMMAND;
                    end
                    else if (ev.op == OP_RX_BYTE && phase_reg == PH_COMMAND
                             && (ev.rx_byte == BYTE_E || ev.rx_byte == BYTE_C))
                    begin
                        r0 = tx(ppages_reg + 8'(bpages_reg));
                        pz = (bpages_reg == 2'd0);
                        pg = 8'd0;
                        settle_ok = pz ? (ppages_reg != 8'd0) : 1'b1;
                        page_next = pg;
                        pz_next = pz;
                        if (settle_ok)
                        begin
                            r1 = erase_res(pz, pg);
                            phase_next = PH_ERASING;
                        end
                        else
                        begin
                            r1 = tx(BYTE_K);
                            bidx_next = '0;
                            phase_next = PH_RECEIVING;
                        end
                        nres = 2'd2;
                    end
                    else if (ev.op == OP_RX_BYTE || ev.op == OP_TIMEOUT)
                    begin
                        r0.start_application = 1'b1;
                        nres = 2'd1;
                        phase_next = PH_ENDED;
                    end
                end
                PH_ERASING, PH_PROGRAMMING:
                begin
                    if (ev.op == OP_RX_BYTE)
                    begin
                        r0.dropped = 1'b1;
                        nres = 2'd1;
                    end
                    else if (ev.op == OP_FLASH_DONE && phase_reg == PH_ERASING)
                    begin
                        r0 = tx(BYTE_E);
                        pg = page_reg + 8'd1;
                        pz = pz_reg;
                        if (!pz && pg >= 8'(bpages_reg))
                        begin
                            pz = 1'b1;
                            pg = 8'd0;
                        end
                        settle_ok = pz ? (pg < ppages_reg) : 1'b1;
                        page_next = pg;
                        pz_next = pz;
                        if (settle_ok)
                            r1 = erase_res(pz, pg);
                        else
                        begin
                            r1 = tx(BYTE_K);
                            bidx_next = '0;
                            phase_next = PH_RECEIVING;
                        end
                        nres = 2'd2;
                    end
                    else if (ev.op == OP_FLASH_DONE)
                    begin
                        cur_next = cur_reg + 7'd1;
                        if (cur_next < wtotal(dcount_reg))
                        begin
                            rd_idx = WW'(cur_next);
                            nres = 2'd1;
                        end
                        else
                        begin
                            r0 = tx(BYTE_K);
                            bidx_next = '0;
                            phase_next = PH_RECEIVING;
                            nres = 2'd1;
                        end
                    end
                end
                PH_RECEIVING:
                begin
                    if (ev.op == OP_TIMEOUT)
                    begin
                        r0.start_application = 1'b1;
                        nres = 2'd1;
                        phase_next = PH_ENDED;
                    end
                    else if (ev.op == OP_RX_BYTE)
                    begin
                        case (bidx_reg)
                            9'd0: dcount_next = ev.rx_byte;
                            9'd1: zone_next = ev.rx_byte[0];
                            9'd2: paddr_next[23:16] = ev.rx_byte;
                            9'd3: paddr_next[15:8] = ev.rx_byte;
                            9'd4: paddr_next[7:0] = ev.rx_byte;
                            default: ;
                        endcase
                        if (bidx_reg >= 9'd5 && bidx_reg == 9'(dcount_reg) + 9'd5)
                        begin
                            cur_next = '0;
                            bidx_next = '0;
                            nres = 2'd1;
                            if (wtotal(dcount_reg) != 7'd0)
                            begin
                                rd_idx = '0;
                                phase_next = PH_PROGRAMMING;
                            end
                            else
                                r0 = tx(BYTE_K);
                        end
                        else
                        begin
                            if (bidx_reg >= 9'd5)
                            begin
                                d = bidx_reg - 9'd5;
                                if (d[8:2] < 7'(MAX_PACKET_WORDS))
                                begin
                                    wr_en = 1'b1;
                                    wr_idx = WW'(d[8:2]);
                                    wr_data = 32'(ev.rx_byte) << {d[1:0], 3'b000};
                                end
                            end
                            bidx_next = bidx_reg + 9'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        // Mark the final beat of the event
        if (nres == 2'd1)
            r0.last = 1'b1;
        else if (nres == 2'd2)
            r1.last = 1'b1;
    end

    // Packet word buffer: byte-lane write, registered read
    logic [1:0] lane;
    assign lane = 2'(bidx_reg - 9'd5);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (lane)
                2'd0: wbuf[wr_idx] <= wr_data;
                2'd1: wbuf[wr_idx][15:8] <= wr_data[15:8];
                2'd2: wbuf[wr_idx][23:16] <= wr_data[23:16];
                default: wbuf[wr_idx][31:24] <= wr_data[31:24];
            endcase
        end
        rd_data <= wbuf[rd_idx];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HANDSHAKE;
            bidx_reg   <= '0;
            dcount_reg <= '0;
            zone_reg   <= 1'b0;
            paddr_reg  <= '0;
            cur_reg    <= '0;
            page_reg   <= '0;
            pz_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bidx_reg   <= bidx_next;
            dcount_reg <= dcount_next;
            zone_reg   <= zone_next;
            paddr_reg  <= paddr_next;
            cur_reg    <= cur_next;
            page_reg   <= page_next;
            pz_reg     <= pz_next;
        end
    end

    // Pending program beat and output buffer
    logic    is_prog;
    result_t pr;
    result_t prog_res;
    assign is_prog = proc && nres == 2'd1 && phase_next == PH_PROGRAMMING
                     && !r0.tx_valid && !r0.dropped;
    always_comb
    begin
        pr = pend_res_reg;
        pr.flash_word = rd_data;
    end

    // Program beat without its word
    always_comb
    begin
        prog_res = '0;
        prog_res.flash_command = CMD_PROGRAM;
        prog_res.flash_address = (zone_next ? BOOT_BASE : PROG_BASE)
            + 29'(paddr_next) + (29'(cur_next) << 2);
        prog_res.last = 1'b1;
    end

    assign out_valid = (ocnt_reg != 2'd0);
    assign out_res   = ob_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg      <= 2'd0;
            ord_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_prog_reg <= 1'b0;
            pend_cur_reg  <= '0;
        end
        else
        begin
            pend_reg <= is_prog;
            pend_prog_reg <= is_prog;
            pend_cur_reg <= cur_next;
            if (pend_reg)
                ocnt_reg <= 2'd1;
            else if (proc && nres != 2'd0 && !is_prog)
                ocnt_reg <= nres;
            else if (out_valid && out_ready)
                ocnt_reg <= ocnt_reg - 2'd1;
            if (pend_reg || (proc && nres != 2'd0 && !is_prog))
                ord_reg <= 1'b0;
            else if (out_valid && out_ready)
                ord_reg <= ~ord_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_prog)
            pend_res_reg <= prog_res;
        if (pend_reg)
            ob_reg[0] <= pr;
        else if (proc && nres == 2'd1)
            ob_reg[0] <= r0;
        else if (proc && nres == 2'd2)
        begin
            ob_reg[0] <= r0;
            ob_reg[1] <= r1;
        end
    end

    `SFL_ASSERT_IMPL(a_take_empty, clk, rst_n, ev_take, ocnt_reg == 2'd0,
        "event taken while results pending")
    `SFL_ASSERT_NEXT(a_pend_fill, clk, rst_n, pend_reg, ocnt_reg == 2'd1,
        "program beat not loaded")
    `SFL_ASSERT_IMPL(a_no_pend_take, clk, rst_n, pend_reg, !ev_take,
        "event taken during word read")
    `SFL_ASSERT_IMPL(a_pend_prog, clk, rst_n, pend_reg, pend_prog_reg && pend_cur_reg < 7'd64,
        "pending beat bookkeeping")

endmodule

### rtl/core/serial_flash_loader_protocol.sv
// ----------------------------------------------------------------------------
// serial_flash_loader_protocol
// Serial boot-loader engine: front queue of events, back protocol engine.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | operation, rx_byte
//  out_ch  | out | valid/ready   | result fields, last marks final beat
//  cfg_ch  | in  | valid/ready   | index, data
//
//  The engine takes one event per cycle while its output buffer is empty.
//  Results drain one beat per cycle while out_ready is high.
//  No event is taken while a program beat waits for its word buffer read.
//  Reset restores the configuration defaults and the handshake phase.
//  The two-entry input queue keeps accepting while results stall, until full.
module serial_flash_loader_protocol
    import sfl_pkg::*;
#(
    parameter int PAGE_BYTES       = 4096,
    parameter int MAX_PACKET_WORDS = 64
)
(
    input logic clk,
    input logic rst_n,
    sfl_in_if.sink    in_ch,
    sfl_out_if.source out_ch,
    sfl_cfg_if.sink   cfg_ch
);

    logic    ev_valid;
    logic    ev_take;
    event_t  ev;
    result_t res;

    assign cfg_ch.ready = 1'b1;

    sfl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_operation (in_ch.operation),
        .in_rx_byte   (in_ch.rx_byte),
        .ev_valid     (ev_valid),
        .ev_take      (ev_take),
        .ev           (ev)
    );

    sfl_back #(
        .PAGE_BYTES       (PAGE_BYTES),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .ev_valid  (ev_valid),
        .ev_take   (ev_take),
        .ev        (ev),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (res)
    );

    assign out_ch.tx_valid          = res.tx_valid;
    assign out_ch.tx_byte           = res.tx_byte;
    assign out_ch.flash_command     = res.flash_command;
    assign out_ch.flash_address     = res.flash_address;
    assign out_ch.flash_word        = res.flash_word;
    assign out_ch.start_application = res.start_application;
    assign out_ch.dropped           = res.dropped;
    assign out_ch.last              = res.last;

endmodule
